FILE: hw/rtl/atisd_pkg.sv
package atisd_pkg;

  localparam int CAPACITY_DEF   = 128;
  localparam int WORD_WIDTH_DEF = 32;

  // fixed field widths of the stream payload
  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FIDX_W   = 7;
  localparam int COUNT_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_DEL_POS = 3'd1,
    CMD_DEL_VAL = 3'd2,
    CMD_SEARCH  = 3'd3,
    CMD_SORT    = 3'd4,
    CMD_READ    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_ABSENT = 2'd3
  } status_t;

  // where a cell takes its next word from
  typedef enum logic [1:0] {
    SRC_LOW  = 2'd0,
    SRC_HIGH = 2'd1,
    SRC_VAL  = 2'd2
  } cell_src_t;

  typedef struct packed {
    logic      load;
    cell_src_t src;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/array_table_insert_delete_search_sort.sv
// Packed table of up to CAPACITY signed words held in a row of cells, with a live count.
// One command per transaction on the input stream and exactly one result transaction on
// the output stream. Insert and delete at position shift the cells in the accepting cycle;
// these, any out-of-range or full refusal and the unused codes then pass to the emit state,
// which registers the result. Search, read and delete value rotate the whole ring of cells
// once past a single comparator at cell 0, and delete value, when it finds its word, then
// closes the gap in a finish state. Sort is an odd-even exchange between neighbouring
// cells, one phase a cycle, when more than one entry is live; otherwise it goes straight
// to the result. A result that finds the output register still occupied waits for it. A
// new command is taken while the previous result still waits in the output register.
module array_table_insert_delete_search_sort import atisd_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position [6:0], value [38:7], zero [39]
  input  logic [2:0]  s_tuser,   // command [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // found_index [6:0], element_value [38:7],
                                 // entry_count [46:39], zero [47]
  output logic [1:0]  m_tuser    // status [1:0]
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ROTATE = 5'b00010,
    ST_SORT   = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  cmd_t                  cmd_q;
  logic [POS_W-1:0]      pos_q;
  logic [WORD_WIDTH-1:0] val_q;
  logic [IDX_W-1:0]      step;
  logic [CNT_W-1:0]      phase;
  logic                  hit;
  logic [IDX_W-1:0]      where_q;
  status_t               res_status;
  logic [IDX_W-1:0]      res_fidx;
  logic [WORD_WIDTH-1:0] res_elem;
  status_t               m_status;
  logic [FIDX_W-1:0]     m_fidx;
  logic [VALUE_W-1:0]    m_elem;
  logic [COUNT_W-1:0]    m_count;

  cell_ctrl_t            ctrl [CAPACITY];
  logic [WORD_WIDTH-1:0] word [CAPACITY];
  logic                  gt   [CAPACITY];

  cmd_t                  in_cmd;
  logic [POS_W-1:0]      in_pos;
  logic signed [63:0]    in_v64;
  logic [WORD_WIDTH-1:0] in_val;
  logic [CMP_W-1:0]      in_pos_c;
  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      count_c;
  logic [CMP_W-1:0]      step_c;
  logic                  full;
  logic                  last_step;
  logic                  hit_now;
  logic                  out_free;
  logic signed [63:0]    elem64;

  assign in_cmd    = cmd_t'(s_tuser);
  assign in_pos    = s_tdata[6:0];
  assign in_v64    = 64'(signed'(s_tdata[38:7]));
  assign in_val    = in_v64[WORD_WIDTH-1:0];
  assign in_pos_c  = CMP_W'(in_pos);
  assign pos_c     = CMP_W'(pos_q);
  assign count_c   = CMP_W'(count);
  assign step_c    = CMP_W'(step);
  assign full      = count == CNT_W'(CAPACITY);
  assign last_step = step == IDX_W'(CAPACITY - 1);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = state == ST_IDLE;

  // cell 0 holds entry step while the ring turns
  assign hit_now = (state == ST_ROTATE) && ((cmd_q == CMD_DEL_VAL) || (cmd_q == CMD_SEARCH))
                   && (step_c < count_c) && (word[0] == val_q);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      atisd_cell #(.WORD_WIDTH(WORD_WIDTH)) u_cell (
        .clk      (clk),
        .ctrl     (ctrl[g]),
        .low_word (word[(g == 0) ? 0 : g - 1]),
        .high_word(word[(g + 1) % CAPACITY]),
        .load_word(in_val),
        .word     (word[g]),
        .gt_high  (gt[g])
      );
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].load = 1'b0;
      ctrl[i].src  = SRC_HIGH;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            case (in_cmd)
              CMD_INSERT: begin
                if (!full && (in_pos_c <= count_c)) begin
                  if (CMP_W'(i) > in_pos_c) begin
                    ctrl[i].load = 1'b1;
                    ctrl[i].src  = SRC_LOW;
                  end else if (CMP_W'(i) == in_pos_c) begin
                    ctrl[i].load = 1'b1;
                    ctrl[i].src  = SRC_VAL;
                  end
                end
              end
              CMD_DEL_POS: begin
                if ((in_pos_c < count_c) && (CMP_W'(i) >= in_pos_c)) begin
                  ctrl[i].load = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ROTATE: ctrl[i].load = 1'b1;
        ST_FINISH: ctrl[i].load = IDX_W'(i) >= where_q;
        ST_SORT: begin
          // pair (i, i+1) is live in this phase when i matches the phase parity
          if ((i + 1 < CAPACITY) && (IDX_W'(i) % 2 == IDX_W'(phase) % 2)
              && (CMP_W'(i + 1) < count_c) && gt[i]) begin
            ctrl[i].load = 1'b1;
            ctrl[i].src  = SRC_HIGH;
          end
          if ((i > 0) && (IDX_W'(i - 1) % 2 == IDX_W'(phase) % 2)
              && (CMP_W'(i) < count_c) && gt[(i == 0) ? 0 : i - 1]) begin
            ctrl[i].load = 1'b1;
            ctrl[i].src  = SRC_LOW;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a result being emitted refills the output register in the same cycle
      if (m_tvalid && m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_q      <= in_cmd;
            pos_q      <= in_pos;
            val_q      <= in_val;
            res_fidx   <= '0;
            res_elem   <= '0;
            hit        <= 1'b0;
            step       <= '0;
            phase      <= '0;
            case (in_cmd)
              CMD_INSERT: begin
                state <= ST_EMIT;
                if (full) begin
                  res_status <= STAT_FULL;
                end else if (in_pos_c > count_c) begin
                  res_status <= STAT_RANGE;
                end else begin
                  res_status <= STAT_OK;
                  count      <= count + 1'b1;
                end
              end
              CMD_DEL_POS: begin
                state <= ST_EMIT;
                if (in_pos_c >= count_c) begin
                  res_status <= STAT_RANGE;
                end else begin
                  res_status <= STAT_OK;
                  count      <= count - 1'b1;
                end
              end
              CMD_DEL_VAL, CMD_SEARCH: begin
                res_status <= STAT_OK;
                state      <= ST_ROTATE;
              end
              CMD_SORT: begin
                res_status <= STAT_OK;
                state      <= (count > CNT_W'(1)) ? ST_SORT : ST_EMIT;
              end
              CMD_READ: begin
                if (in_pos_c >= count_c) begin
                  res_status <= STAT_RANGE;
                  state      <= ST_EMIT;
                end else begin
                  res_status <= STAT_OK;
                  state      <= ST_ROTATE;
                end
              end
              default: begin
                res_status <= STAT_OK;
                state      <= ST_EMIT;
              end
            endcase
          end
        end
        ST_ROTATE: begin
          step <= step + 1'b1;
          if (hit_now) begin
            hit     <= 1'b1;
            where_q <= step;
          end
          if ((cmd_q == CMD_READ) && (step_c == pos_c)) begin
            res_elem <= word[0];
          end
          if (last_step) begin
            if (cmd_q == CMD_DEL_VAL || cmd_q == CMD_SEARCH) begin
              if (hit || hit_now) begin
                res_fidx <= hit_now ? step : where_q;
                state    <= (cmd_q == CMD_DEL_VAL) ? ST_FINISH : ST_EMIT;
              end else begin
                res_status <= STAT_ABSENT;
                state      <= ST_EMIT;
              end
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_FINISH: begin
          count <= count - 1'b1;
          state <= ST_EMIT;
        end
        ST_SORT: begin
          phase <= phase + 1'b1;
          if (phase == count - 1'b1) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_status <= res_status;
            m_fidx   <= FIDX_W'(res_fidx);
            m_elem   <= elem64[VALUE_W-1:0];
            m_count  <= COUNT_W'(count);
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign elem64  = 64'(signed'(res_elem));
  assign m_tdata = {1'b0, m_count, m_elem, m_fidx};
  assign m_tuser = m_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("live count beyond capacity");

  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_FINISH) |=> $stable(count))
    else $error("live count moved outside insert or delete");

  a_rotate_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROTATE && last_step) |=> state != ST_ROTATE)
    else $error("ring rotation ran past one full turn");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("result not moved to the output register");

  a_finish_hit: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> (hit && cmd_q == CMD_DEL_VAL && count != '0))
    else $error("gap closed without a matching entry");

endmodule

FILE: hw/rtl/atisd_cell.sv
module atisd_cell import atisd_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [WORD_WIDTH-1:0] low_word,
  input  logic [WORD_WIDTH-1:0] high_word,
  input  logic [WORD_WIDTH-1:0] load_word,
  output logic [WORD_WIDTH-1:0] word,
  output logic                  gt_high
);

  logic [WORD_WIDTH-1:0] word_next;

  always_comb begin
    case (ctrl.src)
      SRC_LOW:  word_next = low_word;
      SRC_HIGH: word_next = high_word;
      SRC_VAL:  word_next = load_word;
      default:  word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word <= word_next;
    end
  end

  // ordering against the upper neighbour, for the sort exchange
  assign gt_high = $signed(word) > $signed(high_word);

endmodule
